// File: design/integer_text_parser_assert.svh
// Assertion helpers for the integer text parser.
`ifndef INTEGER_TEXT_PARSER_ASSERT_SVH
`define INTEGER_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ITP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/itp_pkg.sv
package itp_pkg;

   localparam int VALUE_W            = 64;
   localparam int OFFSET_W           = 16;
   localparam int BASE_W             = 6;
   localparam int CH_W               = 8;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_LX    = 8'h78;
   localparam logic [CH_W-1:0] CH_UX    = 8'h58;
   localparam logic [CH_W-1:0] CH_LA    = 8'h61;
   localparam logic [CH_W-1:0] CH_LF    = 8'h66;
   localparam logic [CH_W-1:0] CH_UA    = 8'h41;
   localparam logic [CH_W-1:0] CH_UF    = 8'h46;

   // hex letter value = low three bits + 9
   localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            start_req;
   } itp_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] end_offset;
   } itp_result_type;

endpackage

// File: design/integer_text_parser.sv
// Streaming strtol-style integer parser. Feed one string byte per transaction on req_,
// with req_start_req set on the first byte of each string; leading spaces/tabs are skipped,
// one sign is taken, and in base 16 a 0x/0X prefix selects hex digits, otherwise only 0-9
// are taken (acc = acc * base + digit, base 0 means 10). The first byte that does not fit
// produces one rsp_ transaction: the signed value (wraps mod 2^64) and the consumed count
// (saturating; counts the blanks, sign, prefix and digits taken). Bytes after that are
// ignored until the next start; a start in mid-parse drops the old parse silently. Rate:
// one byte per clock, sustained except for the stall described below; on the way to
// rsp_valid the byte lands in the input register, and the combinational parse step feeds
// the result register. The loop through the parser state with its 64x6 multiply-add sets
// the rate. The input side keeps taking bytes while a result waits; it stalls only when
// a byte would produce a second result before the first one is taken.
// csr_base may be written only while the parser is idle.
module integer_text_parser #(
   parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // byte input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [itp_pkg::CH_W-1:0]           req_ch,
   input  logic                               req_start_req,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [itp_pkg::VALUE_W-1:0] rsp_value,
   output logic [itp_pkg::OFFSET_W-1:0]       rsp_end_offset,
   // base register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [itp_pkg::BASE_W-1:0]         csr_base
);
   import itp_pkg::*;

   logic [BASE_W-1:0] base_ff, base_in;

   itp_item_type   req_item;
   itp_item_type   item;
   logic           item_valid;
   logic           advance;
   logic           out_free;
   logic           res_valid;
   itp_result_type res;
   itp_result_type rsp_res;

   // base register: always ready; the user must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_base : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   assign req_item.ch        = req_ch;
   assign req_item.start_req = req_start_req;

   // input register
   itp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   // parse step and parser state
   itp_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .base       (base_ff),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register
   itp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_value      = rsp_res.value;
   assign rsp_end_offset = rsp_res.end_offset;

endmodule

// File: design/itp_in_stage.sv
module itp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  itp_pkg::itp_item_type req_item,
   input  logic                 advance,
   output logic                 req_stall,
   output logic                 item_valid,
   output itp_pkg::itp_item_type item
);
   import itp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   itp_item_type item_ff;
   logic         load;

   // register is free when empty or when its item moves on this cycle
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/itp_core.sv
module itp_core #(
   parameter int COUNT_BITS = itp_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [itp_pkg::BASE_W-1:0]    base,
   input  logic                          item_valid,
   input  itp_pkg::itp_item_type          item,
   input  logic                          out_free,
   output logic                          advance,
   output logic                          res_valid,
   output itp_pkg::itp_result_type        res
);
   import itp_pkg::*;

   `include "integer_text_parser_assert.svh"

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_BLANK  = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_HEX    = 3'd4;
   localparam logic [2:0] PH_DEC    = 3'd5;

   localparam int CW = (COUNT_BITS > OFFSET_W) ? COUNT_BITS : OFFSET_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic [2:0]            phase_ff, phase_in;
   logic [VALUE_W-1:0]    acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [COUNT_BITS-1:0] cons_ff, cons_in;

   logic [2:0]              ph;
   logic [VALUE_W-1:0]      acc_base;
   logic                    neg_base;
   logic [COUNT_BITS-1:0]   cons_base;
   logic [BASE_W-1:0]       mult;
   logic [VALUE_W+BASE_W-1:0] prod;
   logic [CH_W-1:0]         ch;
   logic                    is_blank, is_sign, is_dec, is_alpha, is_x;
   logic [3:0]              hex_digit;
   logic                    take, finish, handled;
   logic [VALUE_W-1:0]      acc_step;
   logic                    neg_step;
   logic [CW-1:0]           cons_wide;

   assign ch        = item.ch;
   assign acc_base  = item.start_req ? '0 : acc_ff;
   assign neg_base  = item.start_req ? 1'b0 : neg_ff;
   assign cons_base = item.start_req ? '0 : cons_ff;
   assign mult      = (base == '0) ? BASE_DEC : base;
   assign prod      = acc_base * mult;

   assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
   assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_alpha  = ((ch >= CH_LA) && (ch <= CH_LF)) || ((ch >= CH_UA) && (ch <= CH_UF));
   assign is_x      = (ch == CH_LX) || (ch == CH_UX);
   assign hex_digit = is_dec ? ch[3:0] : ({1'b0, ch[2:0]} + HEX_ALPHA_OFS);

   // one character through the phase chain; phases fall through like the C switch
   always_comb begin
      ph       = item.start_req ? PH_BLANK : phase_ff;
      acc_step = acc_base;
      neg_step = neg_base;
      take     = 1'b0;
      finish   = 1'b0;
      handled  = 1'b0;
      if (ph == PH_BLANK) begin
         if (is_blank) begin
            take    = 1'b1;
            handled = 1'b1;
         end else if (is_sign) begin
            neg_step = (ch == CH_MINUS);
            take     = 1'b1;
            handled  = 1'b1;
            ph       = PH_SIGNED;
         end else begin
            ph = PH_SIGNED;
         end
      end
      if (!handled && ph == PH_SIGNED) begin
         if (base == BASE_HEX && ch == CH_ZERO) begin
            take    = 1'b1;
            handled = 1'b1;
            ph      = PH_ZERO;
         end else begin
            ph = PH_DEC;
         end
      end
      if (!handled && ph == PH_ZERO) begin
         if (is_x) begin
            take    = 1'b1;
            handled = 1'b1;
            ph      = PH_HEX;
         end else begin
            ph = PH_DEC;
         end
      end
      if (!handled && ph == PH_HEX) begin
         if (is_dec || is_alpha) begin
            acc_step = {acc_base[VALUE_W-5:0], 4'b0000} + VALUE_W'(hex_digit);
            take     = 1'b1;
         end else begin
            finish = 1'b1;
         end
      end else if (!handled && ph == PH_DEC) begin
         if (is_dec) begin
            acc_step = prod[VALUE_W-1:0] + VALUE_W'(ch[3:0]);
            take     = 1'b1;
         end else begin
            finish = 1'b1;
         end
      end
   end

   assign advance   = item_valid && (!finish || out_free);
   assign res_valid = item_valid && finish;

   assign phase_in = advance ? (finish ? PH_IDLE : ph) : phase_ff;
   assign acc_in   = advance ? acc_step : acc_ff;
   assign neg_in   = advance ? neg_step : neg_ff;
   assign cons_in  = advance ? ((take && cons_base != CNT_MAX) ? cons_base + 1'b1 : cons_base)
                             : cons_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         cons_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         cons_ff  <= cons_in;
      end
   end

   // result: stop char leaves acc, sign and count untouched, so use the entry values
   assign cons_wide      = CW'(cons_base);
   assign res.value      = neg_base ? (VALUE_W'(0) - acc_base) : acc_base;
   assign res.end_offset = (cons_wide > CW'({OFFSET_W{1'b1}})) ? {OFFSET_W{1'b1}}
                                                                : cons_wide[OFFSET_W-1:0];

   `ITP_ASSERT_NEXT(a_idle_after_result, clock, reset, advance && res_valid,
      phase_ff == PH_IDLE, "parser not idle after giving a result")
   `ITP_ASSERT_NOW(a_idle_silent, clock, reset,
      item_valid && !item.start_req && phase_ff == PH_IDLE, !res_valid && advance,
      "idle parser reacted to a character without start")
   `ITP_ASSERT_NEXT(a_count_grows, clock, reset,
      advance && !item.start_req && phase_ff != PH_IDLE, cons_ff >= $past(cons_ff),
      "consumed count went backwards inside a parse")

endmodule

// File: design/itp_out_stage.sv
module itp_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  itp_pkg::itp_result_type        res,
   input  logic                          rsp_stall,
   output logic                          out_free,
   output logic                          rsp_valid,
   output itp_pkg::itp_result_type        rsp_res
);
   import itp_pkg::*;

   logic           valid_ff, valid_in;
   itp_result_type res_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = out_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule
